/* rtl/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants of the seam carving engine: word layouts,
// command and status codes, register indexes, sequencer states, sizes.
// ----------------------------------------------------------------------------
package sce_pkg;

  // image store geometry: address is {row, col}
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned ADDR_W     = 2 * COORD_W;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned LINE_DEPTH  = MAX_WIDTH;

  // data widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned ENERGY_W = 9;
  localparam int unsigned COST_W   = 18;
  localparam int unsigned SQ_W     = 18;
  localparam int unsigned SQ_STEPS = SQ_W / 2;
  localparam int unsigned SQ_CNT_W = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NO_IMG  = 2'd2,
    ST_DIM_ONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [PIX_W-1:0]   pixel_intensity;
    logic [COORD_W-1:0] line_index;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] seam_position;
    logic [COST_W-1:0]  seam_cost;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_EL, S_ER, S_EU, S_ED, S_EX, S_EY, S_ES, S_EW,
    S_C0, S_C1, S_C2, S_C3,
    S_TS, S_TC,
    S_TB0, S_TB1, S_TB2, S_TB3,
    S_R0, S_R1, S_R2, S_R3
  } state_t;

endpackage

/* rtl/seam_carving_engine.sv */
// ----------------------------------------------------------------------------
// seam_carving_engine
// Gradient-energy seam carving on an 8-bit intensity image held in on-chip
// pixel, energy and cost memories, driven by one small sequencer.
// ----------------------------------------------------------------------------
// A load word is taken and busy stays low, except on the last pixel of
// an image, which starts a full recompute. A recompute runs the energy
// pass (four single-port pixel reads, two squares on the shared multiplier
// and 9 steps of the square root unit per pixel), the cost pass (one cost
// memory read port), then the trace over the last line and back through
// the remaining lines. A remove shifts the pixels past the seam in each
// line before the recompute. A read with a seam ready answers from the
// S_READ state; a refused read or remove answers straight from idle.
// A direction write with a seam ready runs the cost pass and trace, with
// busy high and cfg_ready low; cfg_ready is also low while start is high.
// Results are one-cycle strobes and cannot be held off; no memory clearing
// is done.
// ----------------------------------------------------------------------------
module seam_carving_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  sce_pkg::in_word_t                 in_data,
  output logic                              out_strobe,
  output sce_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sce_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sce_pkg::*;

  // clamp a size register into 1..max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction

  // line/pos to store address; lines are rows when d is clear, columns when d is set
  function automatic logic [ADDR_W-1:0] lp_addr(input logic d,
                                                input logic [COORD_W-1:0] ln,
                                                input logic [COORD_W-1:0] ps);
    return d ? {ps, ln} : {ln, ps};
  endfunction

  // memories
  logic [PIX_W-1:0]    pix_mem [STORE_DEPTH];
  logic [ENERGY_W-1:0] en_mem  [STORE_DEPTH];
  logic [COST_W-1:0]   co_mem  [STORE_DEPTH];
  logic [COORD_W-1:0]  sm_mem  [LINE_DEPTH];

  logic                pix_we, en_we, co_we, sm_we;
  logic [ADDR_W-1:0]   pix_waddr, pix_raddr, en_waddr, en_raddr, co_waddr, co_raddr;
  logic [COORD_W-1:0]  sm_waddr, sm_raddr;
  logic [PIX_W-1:0]    pix_wdata, pix_rd_r;
  logic [ENERGY_W-1:0] en_wdata, en_rd_r;
  logic [COST_W-1:0]   co_wdata, co_rd_r;
  logic [COORD_W-1:0]  sm_wdata, sm_rd_r;

  // state
  state_t             state_r, state_nxt;
  logic               dir_r, dir_nxt;
  logic [DIM_W-1:0]   img_w_r, img_w_nxt, img_h_r, img_h_nxt;
  logic [DIM_W-1:0]   cur_w_r, cur_w_nxt, cur_h_r, cur_h_nxt;
  logic [COORD_W-1:0] ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic               seam_ready_r, seam_ready_nxt;
  logic               emit_r, emit_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;
  logic [COST_W-1:0]  total_r, total_nxt;
  logic [COORD_W-1:0] i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt, np_r, np_nxt, k_r, k_nxt;
  logic [COST_W-1:0]  best_r, best_nxt, v_r, v_nxt, p_r, p_nxt;
  logic [ENERGY_W-1:0] e_r, e_nxt;
  logic [PIX_W-1:0]   nb_l_r, nb_l_nxt, nb_r_r, nb_r_nxt, nb_u_r, nb_u_nxt, nb_d_r, nb_d_nxt;
  logic [SQ_W-1:0]    acc_r, acc_nxt;

  // helpers
  logic [DIM_W-1:0]    lines, span, w_eff, h_eff;
  logic [COORD_W-1:0]  last_line;
  logic                take, first_pix;
  logic signed [COORD_W-1:0] mul_a;
  logic signed [SQ_W-1:0]    mul_p;
  logic                isq_start, isq_done;
  logic [SQ_STEPS-1:0] isq_root;
  logic                upd;
  logic [COST_W-1:0]   bn, pmin;
  logic [COORD_W-1:0]  pn, npf;
  logic                j_end, i_end;

  sce_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .value (acc_r),
    .done  (isq_done),
    .root  (isq_root)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = !busy && !start;
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

  assign take      = start && !busy;
  assign lines     = dir_r ? cur_w_r : cur_h_r;
  assign span      = dir_r ? cur_h_r : cur_w_r;
  assign last_line = COORD_W'(lines - 1'b1);
  assign first_pix = (ld_row_r == '0) && (ld_col_r == '0);
  assign w_eff     = first_pix ? clamp_dim(img_w_r, DIM_W'(MAX_WIDTH)) : cur_w_r;
  assign h_eff     = first_pix ? clamp_dim(img_h_r, DIM_W'(MAX_HEIGHT)) : cur_h_r;
  assign j_end     = ({1'b0, j_r} + 1'b1 == span);
  assign i_end     = ({1'b0, i_r} + 1'b1 == lines);

  // shared squarer: dx in EX, dy in EY
  assign mul_a = (state_r == S_EX) ?
                 $signed({1'b0, nb_r_r}) - $signed({1'b0, nb_l_r}) :
                 $signed({1'b0, nb_d_r}) - $signed({1'b0, nb_u_r});
  assign mul_p = mul_a * mul_a;

  // trace and cost compare terms
  assign upd  = (j_r == '0) || (co_rd_r < best_r);
  assign bn   = upd ? co_rd_r : best_r;
  assign pn   = upd ? j_r : pos_r;
  assign npf  = (({1'b0, pos_r} + 1'b1 < span) && (co_rd_r < v_r)) ? pos_r + 1'b1 : np_r;
  assign pmin = (({1'b0, j_r} + 1'b1 < span) && (co_rd_r < p_r)) ? co_rd_r : p_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    dir_nxt        = dir_r;
    img_w_nxt      = img_w_r;
    img_h_nxt      = img_h_r;
    cur_w_nxt      = cur_w_r;
    cur_h_nxt      = cur_h_r;
    ld_row_nxt     = ld_row_r;
    ld_col_nxt     = ld_col_r;
    seam_ready_nxt = seam_ready_r;
    emit_nxt       = emit_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    total_nxt      = total_r;
    i_nxt = i_r; j_nxt = j_r; pos_nxt = pos_r; np_nxt = np_r; k_nxt = k_r;
    best_nxt = best_r; v_nxt = v_r; p_nxt = p_r; e_nxt = e_r;
    nb_l_nxt = nb_l_r; nb_r_nxt = nb_r_r; nb_u_nxt = nb_u_r; nb_d_nxt = nb_d_r;
    acc_nxt  = acc_r;
    isq_start = 1'b0;
    pix_we = 1'b0; pix_waddr = {ld_row_r, ld_col_r}; pix_wdata = in_data.pixel_intensity;
    pix_raddr = {i_r, j_r};
    en_we = 1'b0; en_waddr = {i_r, j_r}; en_wdata = isq_root;
    en_raddr = lp_addr(dir_r, i_r, j_r);
    co_we = 1'b0; co_waddr = lp_addr(dir_r, i_r, j_r); co_wdata = {9'd0, en_rd_r};
    co_raddr = lp_addr(dir_r, i_r - 1'b1, j_r);
    sm_we = 1'b0; sm_waddr = i_r; sm_wdata = npf;
    sm_raddr = in_data.line_index;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_data.command)
            CMD_LOAD: begin
              cur_w_nxt      = w_eff;
              cur_h_nxt      = h_eff;
              seam_ready_nxt = 1'b0;
              pix_we         = 1'b1;
              if ({1'b0, ld_col_r} + 1'b1 == w_eff) begin
                ld_col_nxt = '0;
                if ({1'b0, ld_row_r} + 1'b1 == h_eff) begin
                  ld_row_nxt = '0;
                  i_nxt      = '0;
                  j_nxt      = '0;
                  emit_nxt   = 1'b0;
                  state_nxt  = S_EL;
                end else begin
                  ld_row_nxt = ld_row_r + 1'b1;
                end
              end else begin
                ld_col_nxt = ld_col_r + 1'b1;
              end
            end
            CMD_READ: begin
              out_nxt = '{seam_position: '0, seam_cost: '0, status: ST_OK};
              if (!seam_ready_r) begin
                out_nxt.status = ST_NO_IMG;
                out_valid_nxt  = 1'b1;
              end else if ({1'b0, in_data.line_index} >= lines) begin
                out_nxt.status = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            CMD_REMOVE: begin
              out_nxt = '{seam_position: '0, seam_cost: '0, status: ST_OK};
              if (!seam_ready_r) begin
                out_nxt.status = ST_NO_IMG;
                out_valid_nxt  = 1'b1;
              end else if (span <= DIM_W'(1)) begin
                out_nxt.status = ST_DIM_ONE;
                out_valid_nxt  = 1'b1;
              end else begin
                i_nxt     = '0;
                emit_nxt  = 1'b1;
                state_nxt = S_R0;
              end
            end
            default: ;
          endcase
        end else if (cfg_valid) begin
          case (cfg_index)
            REG_DIRECTION: begin
              dir_nxt = cfg_data[0];
              if (seam_ready_r) begin
                i_nxt     = '0;
                j_nxt     = '0;
                emit_nxt  = 1'b0;
                state_nxt = S_C0;
              end
            end
            REG_WIDTH:  img_w_nxt = cfg_data;
            REG_HEIGHT: img_h_nxt = cfg_data;
            default: ;
          endcase
        end
      end

      // seam word read back
      S_READ: begin
        out_nxt       = '{seam_position: sm_rd_r, seam_cost: total_r, status: ST_OK};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // energy: fetch four neighbours
      S_EL: begin
        pix_raddr = {i_r, j_r - 1'b1};
        state_nxt = S_ER;
      end
      S_ER: begin
        nb_l_nxt  = (j_r != '0) ? pix_rd_r : '0;
        pix_raddr = {i_r, j_r + 1'b1};
        state_nxt = S_EU;
      end
      S_EU: begin
        nb_r_nxt  = ({1'b0, j_r} + 1'b1 < cur_w_r) ? pix_rd_r : '0;
        pix_raddr = {i_r - 1'b1, j_r};
        state_nxt = S_ED;
      end
      S_ED: begin
        nb_u_nxt  = (i_r != '0) ? pix_rd_r : '0;
        pix_raddr = {i_r + 1'b1, j_r};
        state_nxt = S_EX;
      end
      S_EX: begin
        nb_d_nxt  = ({1'b0, i_r} + 1'b1 < cur_h_r) ? pix_rd_r : '0;
        acc_nxt   = mul_p;
        state_nxt = S_EY;
      end
      S_EY: begin
        acc_nxt   = acc_r + mul_p;
        state_nxt = S_ES;
      end
      S_ES: begin
        isq_start = 1'b1;
        state_nxt = S_EW;
      end
      S_EW: begin
        if (isq_done) begin
          en_we = 1'b1;
          state_nxt = S_EL;
          if ({1'b0, j_r} + 1'b1 == cur_w_r) begin
            j_nxt = '0;
            if ({1'b0, i_r} + 1'b1 == cur_h_r) begin
              i_nxt     = '0;
              state_nxt = S_C0;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end

      // cost: energy plus minimum of up to three predecessors, energy alone on the first line
      S_C0: begin
        state_nxt = S_C1;
      end
      S_C1: begin
        e_nxt = en_rd_r;
        p_nxt = co_rd_r;
        if (i_r == '0) begin
          co_we = 1'b1;
          state_nxt = S_C0;
          if (j_end) begin
            j_nxt = '0;
            if (i_end) state_nxt = S_TS;
            else i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          co_raddr  = lp_addr(dir_r, i_r - 1'b1, j_r - 1'b1);
          state_nxt = S_C2;
        end
      end
      S_C2: begin
        if ((j_r != '0) && (co_rd_r < p_r)) p_nxt = co_rd_r;
        co_raddr  = lp_addr(dir_r, i_r - 1'b1, j_r + 1'b1);
        state_nxt = S_C3;
      end
      S_C3: begin
        co_we     = 1'b1;
        co_wdata  = COST_W'(e_r) + pmin;
        state_nxt = S_C0;
        if (j_end) begin
          j_nxt = '0;
          if (i_end) state_nxt = S_TS;
          else i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      // trace: first minimum of the last line
      S_TS: begin
        co_raddr  = lp_addr(dir_r, last_line, j_r);
        state_nxt = S_TC;
      end
      S_TC: begin
        best_nxt = bn;
        pos_nxt  = pn;
        if (j_end) begin
          total_nxt = bn;
          sm_we     = 1'b1;
          sm_waddr  = last_line;
          sm_wdata  = pn;
          if (last_line == '0) begin
            seam_ready_nxt = 1'b1;
            out_nxt        = '{seam_position: '0, seam_cost: bn, status: ST_OK};
            out_valid_nxt  = emit_r;
            state_nxt      = S_IDLE;
          end else begin
            i_nxt     = last_line - 1'b1;
            state_nxt = S_TB0;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_TS;
        end
      end
      // trace back one line
      S_TB0: begin
        co_raddr  = lp_addr(dir_r, i_r, pos_r);
        state_nxt = S_TB1;
      end
      S_TB1: begin
        v_nxt     = co_rd_r;
        np_nxt    = pos_r;
        co_raddr  = lp_addr(dir_r, i_r, pos_r - 1'b1);
        state_nxt = S_TB2;
      end
      S_TB2: begin
        if ((pos_r != '0) && (co_rd_r < v_r)) begin
          v_nxt  = co_rd_r;
          np_nxt = pos_r - 1'b1;
        end
        co_raddr  = lp_addr(dir_r, i_r, pos_r + 1'b1);
        state_nxt = S_TB3;
      end
      S_TB3: begin
        sm_we   = 1'b1;
        pos_nxt = npf;
        if (i_r == '0) begin
          seam_ready_nxt = 1'b1;
          out_nxt        = '{seam_position: '0, seam_cost: total_r, status: ST_OK};
          out_valid_nxt  = emit_r;
          state_nxt      = S_IDLE;
        end else begin
          i_nxt     = i_r - 1'b1;
          state_nxt = S_TB0;
        end
      end

      // remove: shift pixels past the seam in by one
      S_R0: begin
        sm_raddr  = i_r;
        state_nxt = S_R1;
      end
      S_R1: begin
        k_nxt     = sm_rd_r;
        state_nxt = S_R2;
      end
      S_R2: begin
        if ({1'b0, k_r} + 1'b1 < span) begin
          pix_raddr = lp_addr(dir_r, i_r, k_r + 1'b1);
          state_nxt = S_R3;
        end else if (i_end) begin
          if (dir_r) cur_h_nxt = cur_h_r - 1'b1;
          else cur_w_nxt = cur_w_r - 1'b1;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_EL;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_R0;
        end
      end
      S_R3: begin
        pix_we    = 1'b1;
        pix_waddr = lp_addr(dir_r, i_r, k_r);
        pix_wdata = pix_rd_r;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_R2;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dir_r        <= 1'b0;
      img_w_r      <= DIM_W'(MAX_WIDTH);
      img_h_r      <= DIM_W'(MAX_HEIGHT);
      cur_w_r      <= '0;
      cur_h_r      <= '0;
      ld_row_r     <= '0;
      ld_col_r     <= '0;
      seam_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dir_r        <= dir_nxt;
      img_w_r      <= img_w_nxt;
      img_h_r      <= img_h_nxt;
      cur_w_r      <= cur_w_nxt;
      cur_h_r      <= cur_h_nxt;
      ld_row_r     <= ld_row_nxt;
      ld_col_r     <= ld_col_nxt;
      seam_ready_r <= seam_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    emit_r  <= emit_nxt;
    out_r   <= out_nxt;
    total_r <= total_nxt;
    i_r <= i_nxt; j_r <= j_nxt; pos_r <= pos_nxt; np_r <= np_nxt; k_r <= k_nxt;
    best_r <= best_nxt; v_r <= v_nxt; p_r <= p_nxt; e_r <= e_nxt;
    nb_l_r <= nb_l_nxt; nb_r_r <= nb_r_nxt; nb_u_r <= nb_u_nxt; nb_d_r <= nb_d_nxt;
    acc_r  <= acc_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    pix_rd_r <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (en_we) en_mem[en_waddr] <= en_wdata;
    en_rd_r <= en_mem[en_raddr];
  end

  always_ff @(posedge clk) begin
    if (co_we) co_mem[co_waddr] <= co_wdata;
    co_rd_r <= co_mem[co_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    sm_rd_r <= sm_mem[sm_raddr];
  end

`ifndef ASSERT_OFF
  // root unit finishes only while the energy pass waits for it
  a_isq_done: assert property (@(posedge clk) disable iff (!rst_n)
    isq_done |-> (state_r == S_EW))
    else $error("square root done outside energy wait");

  // a good status needs a traced seam
  a_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status == ST_OK)) |-> seam_ready_r)
    else $error("ok result without seam");

  // a ready seam belongs to a non-empty image
  a_dims: assert property (@(posedge clk) disable iff (!rst_n)
    seam_ready_r |-> ((cur_w_r != '0) && (cur_h_r != '0)))
    else $error("seam ready with empty image");
`endif

endmodule

/* rtl/sce_isqrt.sv */
// ----------------------------------------------------------------------------
// sce_isqrt
// Iterative integer square root, two radicand bits per cycle (restoring
// digit recurrence). done pulses for one cycle with the floor root.
// ----------------------------------------------------------------------------
module sce_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sce_pkg::SQ_W-1:0]      value,
  output logic                          done,
  output logic [sce_pkg::SQ_STEPS-1:0]  root
);
  import sce_pkg::*;

  logic [SQ_W-1:0]     val_r, val_nxt;
  logic [SQ_STEPS+1:0] rem_r, rem_nxt;
  logic [SQ_STEPS-1:0] root_r, root_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [SQ_STEPS+3:0] rem_sh;
  logic [SQ_STEPS+3:0] trial;

  // start load, or one digit step
  always_comb begin
    rem_sh   = {rem_r, val_r[SQ_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = SQ_CNT_W'(SQ_STEPS);
    end else if (cnt_r != '0) begin
      val_nxt = {val_r[SQ_W-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (rem_sh >= trial) begin
        // remainder stays at most twice the root, so it fits the register
        rem_nxt  = (SQ_STEPS+2)'(rem_sh - trial);
        root_nxt = {root_r[SQ_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[SQ_STEPS+1:0];
        root_nxt = {root_r[SQ_STEPS-2:0], 1'b0};
      end
      done_nxt = (cnt_r == SQ_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* sim/seam_carving_engine_test.sv */
// ----------------------------------------------------------------------------
// seam_carving_engine_test
// Self-checking bench for the seam carving engine. Pixels are loaded into
// images of many sizes and both seam directions, then seams are read and
// removed. Every result word is compared with a built-in model of the
// energy, cost and trace passes, with random gaps on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seam_carving_engine_test;
  import sce_pkg::*;

  localparam int unsigned ROW_PITCH   = 512;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned ITEM_GOAL   = 1050;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_data = '0;
  logic                  out_strobe;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  seam_carving_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  byte unsigned img_pix    [ROW_PITCH*ROW_PITCH];
  int unsigned  img_energy [ROW_PITCH*ROW_PITCH];
  int unsigned  img_cost   [ROW_PITCH*ROW_PITCH];
  int unsigned  seam_line  [ROW_PITCH];
  int unsigned  seam_sum;
  int unsigned  cur_w, cur_h, load_cnt;
  bit           seam_valid;
  bit           reg_dir = 1'b0;
  int unsigned  reg_w = 512, reg_h = 512;

  in_word_t     word_queue[$];
  out_word_t    seam_results[$];
  int unsigned  sender_idle_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  bit           failed = 1'b0;

  function automatic int unsigned at(int unsigned r, int unsigned c);
    return r * ROW_PITCH + c;
  endfunction

  function automatic int unsigned fit_dim(int unsigned v);
    if (v == 0) return 1;
    return (v > 512) ? 512 : v;
  endfunction

  function automatic int unsigned int_root(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 8; b >= 0; b--)
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    return r;
  endfunction

  function automatic void find_energy();
    int l, rt, u, d, dx, dy;
    for (int unsigned r = 0; r < cur_h; r++)
      for (int unsigned c = 0; c < cur_w; c++) begin
        l  = (c > 0) ? img_pix[at(r, c-1)] : 0;
        rt = (c + 1 < cur_w) ? img_pix[at(r, c+1)] : 0;
        u  = (r > 0) ? img_pix[at(r-1, c)] : 0;
        d  = (r + 1 < cur_h) ? img_pix[at(r+1, c)] : 0;
        dx = rt - l;
        dy = d - u;
        img_energy[at(r, c)] = int_root(dx*dx + dy*dy);
      end
  endfunction

  // cumulative cost followed by the trace back from the last line
  function automatic void find_seam();
    int unsigned p, best, pos, np, v;
    if (!reg_dir) begin
      for (int unsigned r = 0; r < cur_h; r++)
        for (int unsigned c = 0; c < cur_w; c++) begin
          if (r == 0) begin
            img_cost[at(r, c)] = img_energy[at(r, c)];
          end else begin
            p = img_cost[at(r-1, c)];
            if (c > 0 && img_cost[at(r-1, c-1)] < p) p = img_cost[at(r-1, c-1)];
            if (c + 1 < cur_w && img_cost[at(r-1, c+1)] < p) p = img_cost[at(r-1, c+1)];
            img_cost[at(r, c)] = img_energy[at(r, c)] + p;
          end
        end
      pos  = 0;
      best = img_cost[at(cur_h-1, 0)];
      for (int unsigned i = 1; i < cur_w; i++)
        if (img_cost[at(cur_h-1, i)] < best) begin
          best = img_cost[at(cur_h-1, i)];
          pos  = i;
        end
      seam_sum = best;
      seam_line[cur_h-1] = pos;
      for (int unsigned i = cur_h - 1; i > 0; i--) begin
        np = pos;
        v  = img_cost[at(i-1, pos)];
        if (pos > 0 && img_cost[at(i-1, pos-1)] < v) begin
          v  = img_cost[at(i-1, pos-1)];
          np = pos - 1;
        end
        if (pos + 1 < cur_w && img_cost[at(i-1, pos+1)] < v) np = pos + 1;
        pos = np;
        seam_line[i-1] = pos;
      end
    end else begin
      for (int unsigned c = 0; c < cur_w; c++)
        for (int unsigned r = 0; r < cur_h; r++) begin
          if (c == 0) begin
            img_cost[at(r, c)] = img_energy[at(r, c)];
          end else begin
            p = img_cost[at(r, c-1)];
            if (r > 0 && img_cost[at(r-1, c-1)] < p) p = img_cost[at(r-1, c-1)];
            if (r + 1 < cur_h && img_cost[at(r+1, c-1)] < p) p = img_cost[at(r+1, c-1)];
            img_cost[at(r, c)] = img_energy[at(r, c)] + p;
          end
        end
      pos  = 0;
      best = img_cost[at(0, cur_w-1)];
      for (int unsigned i = 1; i < cur_h; i++)
        if (img_cost[at(i, cur_w-1)] < best) begin
          best = img_cost[at(i, cur_w-1)];
          pos  = i;
        end
      seam_sum = best;
      seam_line[cur_w-1] = pos;
      for (int unsigned i = cur_w - 1; i > 0; i--) begin
        np = pos;
        v  = img_cost[at(pos, i-1)];
        if (pos > 0 && img_cost[at(pos-1, i-1)] < v) begin
          v  = img_cost[at(pos-1, i-1)];
          np = pos - 1;
        end
        if (pos + 1 < cur_h && img_cost[at(pos+1, i-1)] < v) np = pos + 1;
        pos = np;
        seam_line[i-1] = pos;
      end
    end
  endfunction

  function automatic void apply_reg(reg_idx_t idx, int unsigned val);
    case (idx)
      REG_DIRECTION: begin
        reg_dir = val[0];
        if (seam_valid) find_seam();
      end
      REG_WIDTH:  reg_w = val & 10'h3ff;
      REG_HEIGHT: reg_h = val & 10'h3ff;
      default: ;
    endcase
  endfunction

  // returns 1 when the word produces a result
  function automatic bit apply_word(in_word_t w, output out_word_t res);
    int unsigned total, dim, lines;
    res = '0;
    case (cmd_t'(w.command))
      CMD_LOAD: begin
        if (load_cnt == 0) begin
          cur_w = fit_dim(reg_w);
          cur_h = fit_dim(reg_h);
        end
        seam_valid = 1'b0;
        total = cur_w * cur_h;
        if (load_cnt >= total) load_cnt = 0;
        img_pix[at(load_cnt / cur_w, load_cnt % cur_w)] = w.pixel_intensity;
        load_cnt++;
        if (load_cnt == total) begin
          load_cnt = 0;
          find_energy();
          find_seam();
          seam_valid = 1'b1;
        end
        return 1'b0;
      end
      CMD_READ: begin
        lines = reg_dir ? cur_w : cur_h;
        if (!seam_valid) res.status = ST_NO_IMG;
        else if (w.line_index >= lines) res.status = ST_RANGE;
        else begin
          res.status        = ST_OK;
          res.seam_position = seam_line[w.line_index];
          res.seam_cost     = seam_sum;
        end
        return 1'b1;
      end
      CMD_REMOVE: begin
        dim = reg_dir ? cur_h : cur_w;
        if (!seam_valid) res.status = ST_NO_IMG;
        else if (dim <= 1) res.status = ST_DIM_ONE;
        else begin
          if (!reg_dir) begin
            for (int unsigned i = 0; i < cur_h; i++)
              for (int unsigned k = seam_line[i]; k + 1 < cur_w; k++)
                img_pix[at(i, k)] = img_pix[at(i, k+1)];
            cur_w--;
          end else begin
            for (int unsigned i = 0; i < cur_w; i++)
              for (int unsigned k = seam_line[i]; k + 1 < cur_h; k++)
                img_pix[at(k, i)] = img_pix[at(k+1, i)];
            cur_h--;
          end
          find_energy();
          find_seam();
          res.status    = ST_OK;
          res.seam_cost = seam_sum;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    out_word_t res;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(reg_idx_t'(cfg_index), cfg_data);
      if (start && !busy) begin
        if (apply_word(in_data, res)) seam_results = {seam_results, res};
      end
      if (!start || !busy) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start   <= 1'b1;
          in_data <= word_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    failed = 1'b1;
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (seam_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        exp_w = seam_results.pop_front();
        if (out_data.status !== exp_w.status)
          note_mismatch("status", exp_w.status, out_data.status);
        if (out_data.seam_position !== exp_w.seam_position)
          note_mismatch("seam_position", exp_w.seam_position, out_data.seam_position);
        if (out_data.seam_cost !== exp_w.seam_cost)
          note_mismatch("seam_cost", exp_w.seam_cost, out_data.seam_cost);
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_word(cmd_t cmd, int unsigned pix, int unsigned line);
    in_word_t w;
    w.command         = cmd;
    w.pixel_intensity = pix[7:0];
    w.line_index      = line[8:0];
    word_queue = {word_queue, w};
    if (cmd != CMD_NONE) words_sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for all words to be taken and answered, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (word_queue.size() > 0 || start || seam_results.size() > 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned phase);
    int unsigned raw_w, raw_h, ew, eh, n_ops, sel, span;
    case (phase % 4)
      0: sender_idle_pct = 0;
      1: sender_idle_pct = 68;
      2: sender_idle_pct = 0;
      default: sender_idle_pct = 26;
    endcase
    case ($urandom_range(0, 15))
      0: begin raw_w = 1023; raw_h = 0;    end
      1: begin raw_w = 0;    raw_h = 1023; end
      2: begin raw_w = 512;  raw_h = 1;    end
      default: begin
        raw_w = $urandom_range(1, 8);
        raw_h = $urandom_range(1, 8);
      end
    endcase
    ew = fit_dim(raw_w);
    eh = fit_dim(raw_h);
    write_reg(REG_WIDTH, raw_w);
    write_reg(REG_HEIGHT, raw_h);
    write_reg(REG_DIRECTION, $urandom_range(0, 1));
    span = (ew > eh) ? ew : eh;
    // load the image, with the odd read or noise word inside the load
    for (int unsigned i = 0; i < ew * eh; i++) begin
      push_word(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 511));
      sel = $urandom_range(0, 31);
      if (sel == 0) push_word(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 511));
      else if (sel == 1) push_word(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 511));
    end
    n_ops = $urandom_range(4, 20);
    for (int unsigned i = 0; i < n_ops; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        push_word(CMD_READ, $urandom_range(0, 255), $urandom_range(0, span - 1));
      else if (sel == 5)
        push_word(CMD_READ, $urandom_range(0, 255), $urandom_range(0, 511));
      else if (sel < 9 && (span <= 8 || $urandom_range(0, 7) == 0))
        push_word(CMD_REMOVE, $urandom_range(0, 255), $urandom_range(0, 511));
      else
        push_word(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 511));
    end
    push_word(CMD_READ, 0, 0);
    drain();
  endtask

  initial begin
    int unsigned phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no image yet, then a 3x3 image of extreme pixels
    push_word(CMD_READ, 0, 0);
    push_word(CMD_REMOVE, 255, 511);
    push_word(CMD_NONE, 255, 511);
    drain();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_DIRECTION, 0);
    for (int unsigned i = 0; i < 9; i++) push_word(CMD_LOAD, (i % 2) ? 255 : 0, 0);
    push_word(CMD_READ, 0, 0);
    push_word(CMD_READ, 0, 2);
    push_word(CMD_READ, 0, 3);
    push_word(CMD_READ, 0, 511);
    push_word(CMD_REMOVE, 0, 0);
    push_word(CMD_REMOVE, 0, 0);
    push_word(CMD_REMOVE, 0, 0);
    push_word(CMD_READ, 0, 1);
    drain();

    phase = 0;
    while (words_sent < ITEM_GOAL + 20) begin
      random_phase(phase);
      phase++;
    end
    drain();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sce_pkg.sv
rtl/sce_isqrt.sv
rtl/seam_carving_engine.sv
sim/seam_carving_engine_test.sv
